// ===== sv/dv_pkg.sv =====
package dv_pkg;

    // Width of the payload fields on the channels.
    localparam int unsigned FIELD_WIDTH = 64;

    // Request type codes.
    localparam logic REQ_UNSIGNED = 1'b0;
    localparam logic REQ_SIGNED   = 1'b1;

    // Control carried alongside the data through every pipeline stage.
    typedef struct packed {
        logic valid;
        logic q_neg;
        logic r_neg;
    } dv_ctl_t;

endpackage

// ===== sv/dv_if.sv =====
interface dv_req_if;
    import dv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [FIELD_WIDTH-1:0] dividend;
    logic [FIELD_WIDTH-1:0] divisor;

    modport source (output valid, output req_type, output dividend, output divisor,
                    input ready);
    modport sink   (input valid, input req_type, input dividend, input divisor,
                    output ready);
endinterface

interface dv_rsp_if;
    import dv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] quotient;
    logic [FIELD_WIDTH-1:0] remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

// ===== sv/dv_prep.sv =====
module dv_prep #(
    parameter int unsigned W = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          req_type,
    input  logic [dv_pkg::FIELD_WIDTH-1:0] dividend,
    input  logic [dv_pkg::FIELD_WIDTH-1:0] divisor,
    output dv_pkg::dv_ctl_t               ctl_out,
    output logic [W-1:0]                  n_out,
    output logic [W-1:0]                  d_out
);
    import dv_pkg::*;

    logic [W-1:0] n_raw;
    logic [W-1:0] d_raw;
    logic         n_neg;
    logic         d_neg;
    dv_ctl_t      ctl_reg;
    dv_ctl_t      ctl_next;
    logic [W-1:0] n_reg;
    logic [W-1:0] n_next;
    logic [W-1:0] d_reg;
    logic [W-1:0] d_next;

    assign n_raw = dividend[W-1:0];
    assign d_raw = divisor[W-1:0];
    assign n_neg = (req_type == REQ_SIGNED) && n_raw[W-1];
    assign d_neg = (req_type == REQ_SIGNED) && d_raw[W-1];

    // The most negative value negates to itself, which read unsigned is its magnitude.
    always_comb
    begin
        ctl_next.valid = in_valid;
        ctl_next.q_neg = n_neg ^ d_neg;
        ctl_next.r_neg = n_neg;
        n_next         = n_neg ? (~n_raw + W'(1)) : n_raw;
        d_next         = d_neg ? (~d_raw + W'(1)) : d_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
            d_reg <= d_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign n_out   = n_reg;
    assign d_out   = d_reg;

endmodule

// ===== sv/dv_cell.sv =====
module dv_cell #(
    parameter int unsigned W = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  dv_pkg::dv_ctl_t ctl_in,
    input  logic [W-1:0]    r_in,
    input  logic [W-1:0]    n_in,
    input  logic [W-1:0]    q_in,
    input  logic [W-1:0]    d_in,
    output dv_pkg::dv_ctl_t ctl_out,
    output logic [W-1:0]    r_out,
    output logic [W-1:0]    n_out,
    output logic [W-1:0]    q_out,
    output logic [W-1:0]    d_out
);
    import dv_pkg::*;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         take;
    dv_ctl_t      ctl_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] r_next;
    logic [W-1:0] n_reg;
    logic [W-1:0] n_next;
    logic [W-1:0] q_reg;
    logic [W-1:0] q_next;
    logic [W-1:0] d_reg;

    // The partial remainder keeps a carry bit, so the compare is one bit wider.
    assign shifted = {r_in, n_in[W-1]};
    assign diff    = shifted - {1'b0, d_in};
    assign take    = (shifted >= {1'b0, d_in});

    always_comb
    begin
        r_next = take ? diff[W-1:0] : shifted[W-1:0];
        n_next = {n_in[W-2:0], 1'b0};
        q_next = {q_in[W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            n_reg <= n_next;
            q_reg <= q_next;
            d_reg <= d_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign r_out   = r_reg;
    assign n_out   = n_reg;
    assign q_out   = q_reg;
    assign d_out   = d_reg;

endmodule

// ===== sv/dv_fix.sv =====
module dv_fix #(
    parameter int unsigned W = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  dv_pkg::dv_ctl_t ctl_in,
    input  logic [W-1:0]    q_in,
    input  logic [W-1:0]    r_in,
    output logic            out_valid,
    output logic [W-1:0]    q_out,
    output logic [W-1:0]    r_out
);
    import dv_pkg::*;

    logic         valid_reg;
    logic [W-1:0] q_reg;
    logic [W-1:0] q_next;
    logic [W-1:0] r_reg;
    logic [W-1:0] r_next;

    always_comb
    begin
        q_next = ctl_in.q_neg ? (~q_in + W'(1)) : q_in;
        r_next = ctl_in.r_neg ? (~r_in + W'(1)) : r_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign out_valid = valid_reg;
    assign q_out     = q_reg;
    assign r_out     = r_reg;

endmodule

// ===== sv/restoring_divider_64.sv =====
// Request beats pass in order through one operand stage, DATA_WIDTH (64) subtract cells,
// one sign stage and one output stage. Throughput: one request beat per cycle while the
// skid entry is empty; each cell retires one quotient bit per cycle while the pipe advances.
// A stalled output beat is caught by a one-entry skid register, and the pipe stops only
// once that entry is full. Reset (rst_n, asynchronous, active low) clears all valid bits.
module restoring_divider_64 #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input logic      clk,
    input logic      rst_n,
    dv_req_if.sink   req,
    dv_rsp_if.source rsp
);
    import dv_pkg::*;

    localparam int unsigned W = DATA_WIDTH;

    logic         advance;
    dv_ctl_t      ctl_chain [0:W];
    logic [W-1:0] r_chain   [0:W];
    logic [W-1:0] n_chain   [0:W];
    logic [W-1:0] q_chain   [0:W];
    logic [W-1:0] d_chain   [0:W];
    logic         fix_valid;
    logic [W-1:0] fix_q;
    logic [W-1:0] fix_r;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [FIELD_WIDTH-1:0] out_q_reg;
    logic [FIELD_WIDTH-1:0] out_q_next;
    logic [FIELD_WIDTH-1:0] out_r_reg;
    logic [FIELD_WIDTH-1:0] out_r_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic [FIELD_WIDTH-1:0] skid_q_reg;
    logic [FIELD_WIDTH-1:0] skid_r_reg;
    logic                   out_load;
    logic                   pipe_beat;

    // The whole pipe moves together; it halts only while the skid entry is occupied.
    assign advance   = !skid_valid_reg;
    assign req.ready = advance;

    dv_prep #(.W(W)) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (req.valid),
        .req_type (req.req_type),
        .dividend (req.dividend),
        .divisor  (req.divisor),
        .ctl_out  (ctl_chain[0]),
        .n_out    (n_chain[0]),
        .d_out    (d_chain[0])
    );

    assign r_chain[0] = '0;
    assign q_chain[0] = '0;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        dv_cell #(.W(W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (advance),
            .ctl_in  (ctl_chain[i]),
            .r_in    (r_chain[i]),
            .n_in    (n_chain[i]),
            .q_in    (q_chain[i]),
            .d_in    (d_chain[i]),
            .ctl_out (ctl_chain[i+1]),
            .r_out   (r_chain[i+1]),
            .n_out   (n_chain[i+1]),
            .q_out   (q_chain[i+1]),
            .d_out   (d_chain[i+1])
        );
    end

    dv_fix #(.W(W)) u_fix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .ctl_in    (ctl_chain[W]),
        .q_in      (q_chain[W]),
        .r_in      (r_chain[W]),
        .out_valid (fix_valid),
        .q_out     (fix_q),
        .r_out     (fix_r)
    );

    assign pipe_beat = fix_valid && advance;
    assign out_load  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_q_next      = out_q_reg;
        out_r_next      = out_r_reg;
        skid_valid_next = skid_valid_reg;
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_q_next      = skid_q_reg;
                out_r_next      = skid_r_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = pipe_beat;
                out_q_next     = FIELD_WIDTH'(fix_q);
                out_r_next     = FIELD_WIDTH'(fix_r);
            end
        end
        else if (pipe_beat)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_q_reg <= out_q_next;
        out_r_reg <= out_r_next;
        if (!out_load && pipe_beat)
        begin
            skid_q_reg <= FIELD_WIDTH'(fix_q);
            skid_r_reg <= FIELD_WIDTH'(fix_r);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.quotient  = out_q_reg;
    assign rsp.remainder = out_r_reg;

endmodule

// ===== sv/dv_chk.sv =====
module dv_chk #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [dv_pkg::FIELD_WIDTH-1:0] quotient,
    input logic [dv_pkg::FIELD_WIDTH-1:0] remainder
);
    import dv_pkg::*;

    // Operand stage, one stage per cell, sign stage, output register and skid entry.
    localparam int unsigned DEPTH = DATA_WIDTH + 4;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic             req_beat;
    logic             rsp_beat;
    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_beat && !rsp_beat)
        begin
            pending_next = pending_reg + CNT_W'(1);
        end
        else if (!req_beat && rsp_beat)
        begin
            pending_next = pending_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled response beat keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(quotient) && $stable(remainder))
        else $error("response beat changed while stalled");

    // Requests are refused only after the response side held off a beat.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> $past(rsp_valid && !rsp_ready))
        else $error("request side stalled without a stalled response");

    // Every response beat belongs to an accepted request.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != '0)
        else $error("response beat without an outstanding request");

    // The pipe never holds more beats than it has stages.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(DEPTH))
        else $error("more beats in flight than the pipe can hold");

endmodule

bind restoring_divider_64 dv_chk #(.DATA_WIDTH(DATA_WIDTH)) u_dv_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .quotient  (rsp.quotient),
    .remainder (rsp.remainder)
);

// ===== tb/quot_rem_monitor.sv =====
module quot_rem_monitor
    import dv_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    dv_req_if           req,
    dv_rsp_if           rsp,
    output int unsigned fail_count,
    output int unsigned outstanding,
    output int unsigned results_checked
);

    localparam int unsigned REPORT_CAP = 60;

    typedef struct {
        logic                   req_type;
        logic [FIELD_WIDTH-1:0] dividend;
        logic [FIELD_WIDTH-1:0] divisor;
        logic [FIELD_WIDTH-1:0] quotient;
        logic [FIELD_WIDTH-1:0] remainder;
    } quot_rem_t;

    quot_rem_t pending_q[$];

    // Divides the magnitudes with one restoring step per bit, MSB first, then applies the
    // sign rules. The partial remainder has one bit more than the data, so divisors with
    // the top bit set come out exact, and a zero divisor gives an all-ones quotient magnitude.
    function automatic quot_rem_t divide_expect(input logic rtype,
                                                input logic [FIELD_WIDTH-1:0] a,
                                                input logic [FIELD_WIDTH-1:0] b);
        quot_rem_t              res;
        logic [FIELD_WIDTH-1:0] mask;
        logic [FIELD_WIDTH-1:0] n;
        logic [FIELD_WIDTH-1:0] d;
        logic [FIELD_WIDTH-1:0] q;
        logic [FIELD_WIDTH-1:0] rem;
        logic [FIELD_WIDTH:0]   part;
        logic                   n_neg;
        logic                   d_neg;
        mask  = {FIELD_WIDTH{1'b1}} >> (FIELD_WIDTH - DATA_WIDTH);
        n     = a & mask;
        d     = b & mask;
        n_neg = (rtype == REQ_SIGNED) && n[DATA_WIDTH-1];
        d_neg = (rtype == REQ_SIGNED) && d[DATA_WIDTH-1];
        if (n_neg)
            n = (~n + 1'b1) & mask;
        if (d_neg)
            d = (~d + 1'b1) & mask;
        q    = '0;
        part = '0;
        for (int i = DATA_WIDTH - 1; i >= 0; i--)
        begin
            part = {part[FIELD_WIDTH-1:0], n[i]};
            if (part >= {1'b0, d})
            begin
                part = part - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        rem = part[FIELD_WIDTH-1:0];
        // The most negative value over minus one wraps back onto itself here.
        if (n_neg != d_neg)
            q = (~q + 1'b1) & mask;
        if (n_neg)
            rem = (~rem + 1'b1) & mask;
        res.req_type  = rtype;
        res.dividend  = a;
        res.divisor   = b;
        res.quotient  = q;
        res.remainder = rem;
        return res;
    endfunction

    function automatic void report_mismatch(input string what, input quot_rem_t op,
                                            input logic [FIELD_WIDTH-1:0] want,
                                            input logic [FIELD_WIDTH-1:0] got);
        if (fail_count < REPORT_CAP)
            $display("%0t: %s mismatch, %h / %h signed=%0b: expected %h, actual %h",
                     $time, what, op.dividend, op.divisor, op.req_type, want, got);
        else if (fail_count == REPORT_CAP)
            $display("%0t: further mismatches are counted but not listed", $time);
        fail_count++;
    endfunction

    initial
    begin
        fail_count      = 0;
        outstanding     = 0;
        results_checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        quot_rem_t want;
        if (!rst_n)
        begin
            pending_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                pending_q.push_back(divide_expect(req.req_type, req.dividend, req.divisor));
            if (rsp.valid && rsp.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    if (fail_count < REPORT_CAP)
                        $display("%0t: stray response: expected nothing, actual q=%h r=%h",
                                 $time, rsp.quotient, rsp.remainder);
                    fail_count++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    results_checked++;
                    if (rsp.quotient !== want.quotient)
                        report_mismatch("quotient", want, want.quotient, rsp.quotient);
                    if (rsp.remainder !== want.remainder)
                        report_mismatch("remainder", want, want.remainder, rsp.remainder);
                end
            end
            outstanding = pending_q.size();
        end
    end

endmodule

// ===== tb/restoring_divider_64_test.sv =====
module restoring_divider_64_test;
    import dv_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_WAIT  = 80;

    localparam logic [FIELD_WIDTH-1:0] ALL_ONES = {FIELD_WIDTH{1'b1}};
    localparam logic [FIELD_WIDTH-1:0] MIN_S    = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
    localparam logic [FIELD_WIDTH-1:0] MAX_S    = {1'b0, {(FIELD_WIDTH-1){1'b1}}};

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned results_checked;
    int unsigned cycle_count;
    int unsigned beats_sent;
    int unsigned signed_beats;
    int unsigned zero_divisors;
    bit          sender_idle;
    bit          sink_idle;
    bit          hold_off_req;

    dv_req_if req();
    dv_rsp_if rsp();

    restoring_divider_64 i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    quot_rem_monitor i_quot_rem_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one request beat and waits for the edge that takes it. Ready is looked at
    // on the falling edge, where nothing changes; with sender_idle it may then idle.
    task automatic offer_div(input logic rtype, input logic [FIELD_WIDTH-1:0] a,
                             input logic [FIELD_WIDTH-1:0] b);
        bit took;
        req.valid    <= 1'b1;
        req.req_type <= rtype;
        req.dividend <= a;
        req.divisor  <= b;
        do
        begin
            @(negedge clk);
            took = req.ready;
            @(posedge clk);
        end
        while (!took);
        beats_sent++;
        if (rtype == REQ_SIGNED)
            signed_beats++;
        if (b == '0)
            zero_divisors++;
        if (sender_idle && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        req.valid <= 1'b0;
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    function automatic logic [FIELD_WIDTH-1:0] pick_operand();
        logic [FIELD_WIDTH-1:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            2: return FIELD_WIDTH'($urandom_range(0, 20));
            3: return ~FIELD_WIDTH'($urandom_range(0, 19));
            4: return FIELD_WIDTH'(1) << $urandom_range(0, FIELD_WIDTH - 1);
            5: return full >> $urandom_range(0, FIELD_WIDTH - 1);
            6:
            begin
                case ($urandom_range(0, 4))
                    0: return MIN_S;
                    1: return MAX_S;
                    2: return ALL_ONES;
                    3: return FIELD_WIDTH'(1);
                    default: return MIN_S + 1'b1;
                endcase
            end
            7: return full | MIN_S;
            default: return full;
        endcase
    endfunction

    task automatic random_divs(input int unsigned count);
        logic [FIELD_WIDTH-1:0] b;
        repeat (count)
        begin
            b = ($urandom_range(0, 39) == 0) ? '0 : pick_operand();
            offer_div($urandom_range(0, 1) ? REQ_SIGNED : REQ_UNSIGNED, pick_operand(), b);
        end
    endtask

    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                // A long stall so that the pipe fills and request beats back up.
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 2) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat (sink_idle ? $urandom_range(1, 24) : 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        cycle_count   = 0;
        beats_sent    = 0;
        signed_beats  = 0;
        zero_divisors = 0;
        sender_idle   = 1'b0;
        sink_idle     = 1'b1;
        hold_off_req  = 1'b0;
        rst_n         = 1'b0;
        req.valid    <= 1'b0;
        req.req_type <= REQ_UNSIGNED;
        req.dividend <= '0;
        req.divisor  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_div(REQ_UNSIGNED, '0, FIELD_WIDTH'(1));
        offer_div(REQ_UNSIGNED, ALL_ONES, FIELD_WIDTH'(1));
        offer_div(REQ_UNSIGNED, ALL_ONES, ALL_ONES);
        offer_div(REQ_UNSIGNED, FIELD_WIDTH'(12345), '0);
        offer_div(REQ_UNSIGNED, '0, '0);
        offer_div(REQ_UNSIGNED, ALL_ONES, MIN_S);
        offer_div(REQ_UNSIGNED, MIN_S, ALL_ONES);
        offer_div(REQ_UNSIGNED, FIELD_WIDTH'(1), ALL_ONES);
        offer_div(REQ_UNSIGNED, ALL_ONES, FIELD_WIDTH'(2));
        offer_div(REQ_UNSIGNED, FIELD_WIDTH'(100), FIELD_WIDTH'(7));
        offer_div(REQ_SIGNED, MIN_S, ALL_ONES);
        offer_div(REQ_SIGNED, MIN_S, FIELD_WIDTH'(1));
        offer_div(REQ_SIGNED, -FIELD_WIDTH'(7), FIELD_WIDTH'(2));
        offer_div(REQ_SIGNED, FIELD_WIDTH'(7), -FIELD_WIDTH'(2));
        offer_div(REQ_SIGNED, -FIELD_WIDTH'(7), -FIELD_WIDTH'(2));
        offer_div(REQ_SIGNED, -FIELD_WIDTH'(5), '0);
        offer_div(REQ_SIGNED, FIELD_WIDTH'(5), '0);
        offer_div(REQ_SIGNED, MIN_S, '0);
        offer_div(REQ_SIGNED, MIN_S, MIN_S);
        offer_div(REQ_SIGNED, MAX_S, MIN_S);
        offer_div(REQ_SIGNED, '0, ALL_ONES);
        offer_div(REQ_SIGNED, ALL_ONES, ALL_ONES);
        offer_div(REQ_SIGNED, MAX_S, MAX_S);
        wait_all_results();

        sender_idle = 1'b1;
        random_divs(300);
        wait_all_results();

        // The sender keeps offering back to back while the response side holds off.
        hold_off_req = 1'b1;
        sender_idle  = 1'b0;
        random_divs(150);

        sender_idle = 1'b1;
        random_divs(150);

        sender_idle = 1'b0;
        sink_idle   = 1'b0;
        random_divs(100);

        req.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d request beats (%0d signed, %0d with a zero divisor), checked %0d",
                 beats_sent, signed_beats, zero_divisors, results_checked);
        $display("Covered operand extremes, sign rules, overflow wrap and a filled pipe");
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dv_pkg.sv
sv/dv_if.sv
sv/dv_prep.sv
sv/dv_cell.sv
sv/dv_fix.sv
sv/restoring_divider_64.sv
sv/dv_chk.sv
tb/quot_rem_monitor.sv
tb/restoring_divider_64_test.sv
